>>> hdl/keyboard_controller_with_fifo_core_macros.svh
// Assertion macros for the keyboard controller RTL; included by kbc_fifo.
// Expects i_clk and i_rst_n in the scope that uses them; no other dependencies.
`ifndef KEYBOARD_CONTROLLER_WITH_FIFO_CORE_MACROS_SVH
`define KEYBOARD_CONTROLLER_WITH_FIFO_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KBC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/kbc_pkg.sv
// Shared types, codes and constants of the keyboard controller.
// No dependencies; used by kbc_fifo, kbc_ctrl and the top level.
package kbc_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_BUS_WRITE = 2'd0,
        OP_BUS_READ  = 2'd1,
        OP_KEY_BYTE  = 2'd2,
        OP_POLL      = 2'd3
    } t_op;

    // Decoded port offsets (port minus 0x60)
    localparam logic [2:0] OFF_DATA   = 3'd0;
    localparam logic [2:0] OFF_PORT_B = 3'd1;
    localparam logic [2:0] OFF_STATUS = 3'd4;

    // Command bytes
    localparam logic [7:0] CMD_SELF_TEST  = 8'h01;
    localparam logic [7:0] CMD_ECHO_ZERO  = 8'h02;
    localparam logic [7:0] CMD_READ_ID    = 8'h05;
    localparam logic [7:0] CMD_LOAD_SCAN  = 8'h11;
    localparam logic [7:0] CMD_LOAD_MOUSE = 8'h12;

    localparam logic [7:0] SELF_TEST_OK   = 8'hAA;
    localparam logic [7:0] UNDECODED_READ = 8'hFF;
    localparam logic [7:0] STATUS_RD_MASK = 8'h0F;

    // Parameter byte counts
    localparam logic [3:0] PARAM_MAX        = 4'd9;
    localparam logic [3:0] PARAM_GOAL_SCAN  = 4'd9;
    localparam logic [3:0] PARAM_GOAL_MOUSE = 4'd4;

    // Status byte bit positions and reset value
    localparam int ST_OFULL     = 0;
    localparam int ST_IFULL     = 1;
    localparam int ST_CD        = 3;
    localparam int ST_TIMEOUT_A = 5;
    localparam int ST_TIMEOUT_B = 6;
    localparam logic [7:0] STATUS_RESET = 8'h18;

    localparam logic [7:0] KBD_ID_RESET = 8'h10;

    typedef struct packed {
        logic       enq;
        logic [7:0] enq_data;
        logic       deq;
    } t_fifo_req;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head_data;
    } t_fifo_stat;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
        logic       speaker_gate;
        logic       speaker_data;
        logic       mouse_mode;
        logic       fifo_dropped;
    } t_result;

    function automatic logic [FIFO_AW-1:0] ptr_next(input logic [FIFO_AW-1:0] p);
        logic [FIFO_AW-1:0] nxt;
        nxt = (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
        return nxt;
    endfunction

endpackage

>>> hdl/kbc_fifo.sv
// Key byte queue: register file with head/tail pointers and a fill count.
// Depends on kbc_pkg and keyboard_controller_with_fifo_core_macros.svh.
`include "keyboard_controller_with_fifo_core_macros.svh"

module kbc_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kbc_pkg::t_fifo_req    i_req,
    output kbc_pkg::t_fifo_stat   o_stat
);

    logic [7:0]                  r_mem [kbc_pkg::FIFO_DEPTH];
    logic [kbc_pkg::FIFO_AW-1:0] r_head;
    logic [kbc_pkg::FIFO_AW-1:0] r_tail;
    logic [kbc_pkg::FIFO_CW-1:0] r_count;

    logic do_enq;
    logic do_deq;

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == kbc_pkg::FIFO_CW'(kbc_pkg::FIFO_DEPTH));
    assign o_stat.head_data = r_mem[r_head];

    // a byte offered to a full queue is discarded
    assign do_enq = i_req.enq && !o_stat.full;
    assign do_deq = i_req.deq && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[r_tail] <= i_req.enq_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_enq) begin
                r_tail <= kbc_pkg::ptr_next(r_tail);
            end
            if (do_deq) begin
                r_head <= kbc_pkg::ptr_next(r_head);
            end
            if (do_enq && !do_deq) begin
                r_count <= r_count + 1'b1;
            end else if (do_deq && !do_enq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `KBC_ASSERT_SAME(a_count_bound, 1'b1,
        r_count <= kbc_pkg::FIFO_CW'(kbc_pkg::FIFO_DEPTH), "fifo count over depth")
    `KBC_ASSERT_SAME(a_empty_ptrs, r_count == '0, r_head == r_tail,
        "empty fifo with unequal pointers")
    `KBC_ASSERT_SAME(a_single_op, i_req.enq, !i_req.deq, "enqueue and dequeue together")
    `KBC_ASSERT_NEXT(a_count_inc, i_req.enq && !o_stat.full && !i_req.deq,
        r_count == $past(r_count) + 1'b1, "accepted byte not counted")

endmodule

>>> hdl/kbc_ctrl.sv
// Controller state: output latch, status, interrupt arm, command and parameters,
// port B and mouse flag; decodes one request per cycle while i_fire is high. Depends on kbc_pkg.
module kbc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  kbc_pkg::t_op          i_op,
    input  logic [2:0]            i_off,
    input  logic [7:0]            i_data,
    input  logic [7:0]            i_kbd_id,
    input  kbc_pkg::t_fifo_stat   i_fifo,
    output kbc_pkg::t_fifo_req    o_fifo,
    output kbc_pkg::t_result      o_result
);

    logic [7:0] r_latch,  n_latch;
    logic [7:0] r_status, n_status;
    logic       r_want,   n_want;
    logic [7:0] r_cmd,    n_cmd;
    logic [3:0] r_pidx,   n_pidx;
    logic [3:0] r_pgoal,  n_pgoal;
    logic       r_mouse,  n_mouse;
    logic [7:0] r_port_b, n_port_b;

    logic       enq;
    logic [7:0] enq_data;
    logic       deq;
    logic [7:0] rd;
    logic       irq;

    always_comb begin
        n_latch  = r_latch;
        n_status = r_status;
        n_want   = r_want;
        n_cmd    = r_cmd;
        n_pidx   = r_pidx;
        n_pgoal  = r_pgoal;
        n_mouse  = r_mouse;
        n_port_b = r_port_b;
        enq      = 1'b0;
        enq_data = '0;
        deq      = 1'b0;
        rd       = '0;
        irq      = 1'b0;
        if (i_fire) begin
            unique case (i_op)
                kbc_pkg::OP_BUS_WRITE: begin
                    unique case (i_off)
                        kbc_pkg::OFF_DATA: begin
                            n_status[kbc_pkg::ST_CD] = 1'b0;
                            if (r_pidx != r_pgoal && r_pidx < kbc_pkg::PARAM_MAX) begin
                                n_pidx = r_pidx + 1'b1;
                                if (n_pidx == r_pgoal) begin
                                    priority if (r_cmd == kbc_pkg::CMD_LOAD_SCAN) begin
                                        n_mouse = 1'b0;
                                    end else if (r_cmd == kbc_pkg::CMD_LOAD_MOUSE) begin
                                        n_mouse = 1'b1;
                                    end
                                end
                            end else begin
                                n_cmd = i_data;
                                unique case (i_data)
                                    kbc_pkg::CMD_SELF_TEST: begin
                                        enq      = 1'b1;
                                        enq_data = kbc_pkg::SELF_TEST_OK;
                                    end
                                    kbc_pkg::CMD_ECHO_ZERO: begin
                                        enq      = 1'b1;
                                        enq_data = '0;
                                    end
                                    kbc_pkg::CMD_READ_ID: begin
                                        enq      = 1'b1;
                                        enq_data = i_kbd_id;
                                    end
                                    kbc_pkg::CMD_LOAD_SCAN: begin
                                        n_pidx  = '0;
                                        n_pgoal = kbc_pkg::PARAM_GOAL_SCAN;
                                    end
                                    kbc_pkg::CMD_LOAD_MOUSE: begin
                                        n_pidx  = '0;
                                        n_pgoal = kbc_pkg::PARAM_GOAL_MOUSE;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        kbc_pkg::OFF_PORT_B: begin
                            n_port_b = i_data;
                        end
                        kbc_pkg::OFF_STATUS: begin
                            n_status[kbc_pkg::ST_CD] = 1'b1;
                            if (i_data == kbc_pkg::CMD_ECHO_ZERO) begin
                                enq      = 1'b1;
                                enq_data = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                kbc_pkg::OP_BUS_READ: begin
                    unique case (i_off)
                        kbc_pkg::OFF_DATA: begin
                            rd = r_latch;
                            if (i_fifo.empty) begin
                                n_status[kbc_pkg::ST_OFULL] = 1'b0;
                                n_want = 1'b0;
                            end else begin
                                deq = 1'b1;
                            end
                        end
                        kbc_pkg::OFF_PORT_B: begin
                            rd = r_port_b;
                        end
                        kbc_pkg::OFF_STATUS: begin
                            rd = r_status & kbc_pkg::STATUS_RD_MASK;
                            n_status[kbc_pkg::ST_TIMEOUT_A] = 1'b0;
                            n_status[kbc_pkg::ST_TIMEOUT_B] = 1'b0;
                        end
                        default: begin
                            rd = kbc_pkg::UNDECODED_READ;
                        end
                    endcase
                end
                kbc_pkg::OP_KEY_BYTE: begin
                    enq      = 1'b1;
                    enq_data = i_data;
                end
                kbc_pkg::OP_POLL: begin
                    if (r_want) begin
                        n_want = 1'b0;
                        irq    = 1'b1;
                    end
                    if (!r_status[kbc_pkg::ST_OFULL] && !i_fifo.empty) begin
                        deq = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            // next queued byte into the latch; re-arms the interrupt
            if (deq) begin
                n_latch = i_fifo.head_data;
                n_status[kbc_pkg::ST_OFULL] = 1'b1;
                n_status[kbc_pkg::ST_IFULL] = 1'b0;
                n_want = 1'b1;
            end
        end
    end

    assign o_fifo.enq      = enq;
    assign o_fifo.enq_data = enq_data;
    assign o_fifo.deq      = deq;

    assign o_result.read_data    = rd;
    assign o_result.irq_request  = irq;
    assign o_result.speaker_gate = n_port_b[0];
    assign o_result.speaker_data = n_port_b[1];
    assign o_result.mouse_mode   = n_mouse;
    assign o_result.fifo_dropped = enq && i_fifo.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch  <= '0;
            r_status <= kbc_pkg::STATUS_RESET;
            r_want   <= 1'b0;
            r_cmd    <= '0;
            r_pidx   <= '0;
            r_pgoal  <= '0;
            r_mouse  <= 1'b0;
            r_port_b <= '0;
        end else begin
            r_latch  <= n_latch;
            r_status <= n_status;
            r_want   <= n_want;
            r_cmd    <= n_cmd;
            r_pidx   <= n_pidx;
            r_pgoal  <= n_pgoal;
            r_mouse  <= n_mouse;
            r_port_b <= n_port_b;
        end
    end

endmodule

>>> hdl/keyboard_controller_with_fifo_core.sv
// Keyboard controller core with a key byte queue; uses kbc_pkg, kbc_fifo, kbc_ctrl.
// A request is held in the input register, then its result in the result register,
// where it is taken when the downstream does not stall; both hold while stalled.
// Throughput: one request per cycle unless stalled; each is fully resolved in one pass.
// Reset (i_rst_n low, synchronous) empties the queue, clears latch, command and port B,
// loads status 0x18 and keyboard ID 0x10; queue contents are not cleared.
module keyboard_controller_with_fifo_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: keyboard ID byte
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_port_offset,
    input  logic [7:0] i_data_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_irq_request,
    output logic       o_speaker_gate,
    output logic       o_speaker_data,
    output logic       o_mouse_mode,
    output logic       o_fifo_dropped
);

    // Keyboard ID register; the user must write it only while the core is idle (not enforced here)
    logic [7:0] r_kbd_id;

    // Input register
    logic          r_in_valid;
    kbc_pkg::t_op  r_op;
    logic [2:0]    r_off;
    logic [7:0]    r_data;

    // Result register
    logic              r_out_valid;
    kbc_pkg::t_result  r_result;

    logic                 out_blocked;
    logic                 fire;
    logic                 in_accept;
    kbc_pkg::t_fifo_req   fifo_req;
    kbc_pkg::t_fifo_stat  fifo_stat;
    kbc_pkg::t_result     result;

    // The result register holds while the downstream stalls; the input register
    // then holds too, so the stall reaches the upstream only when both are full.
    assign out_blocked = r_out_valid && i_out_stall;
    assign fire        = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbd_id <= kbc_pkg::KBD_ID_RESET;
        end else if (i_cfg_we) begin
            r_kbd_id <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= kbc_pkg::t_op'(i_operation);
            r_off  <= i_port_offset;
            r_data <= i_data_byte;
        end
    end

    // Queue state and controller state both update on the cycle the request fires
    kbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fifo_req),
        .o_stat  (fifo_stat)
    );

    kbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_op     (r_op),
        .i_off    (r_off),
        .i_data   (r_data),
        .i_kbd_id (r_kbd_id),
        .i_fifo   (fifo_stat),
        .o_fifo   (fifo_req),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_result.read_data;
    assign o_irq_request  = r_result.irq_request;
    assign o_speaker_gate = r_result.speaker_gate;
    assign o_speaker_data = r_result.speaker_data;
    assign o_mouse_mode   = r_result.mouse_mode;
    assign o_fifo_dropped = r_result.fifo_dropped;

endmodule
